FILE: sv/ubdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the second-modulator lookup for the UART
// baud divisor calculator. No dependencies.
package ubdc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int TABLE_ENTRIES = 36;
    localparam int WORD_W        = 32;
    localparam int PRES_W        = 16;
    localparam int FMOD_W        = 4;
    localparam int SMOD_W        = 8;
    localparam int THR_W         = 16;
    localparam int DVD_W         = WORD_W + FRACTION_BITS;
    localparam int QUO_W         = DVD_W;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] CLK_HZ_RESET     = WORD_W'(3000000);
    localparam logic [WORD_W-1:0] FALLBACK_BAUD    = WORD_W'(9600);
    localparam logic [QUO_W-1:0]  OVER_LIMIT_FIX   = QUO_W'(19) << FRACTION_BITS;

    localparam logic [THR_W-1:0] MOD_THRESH [TABLE_ENTRIES] = '{
        16'd0,     16'd3467,  16'd4686,  16'd5472,  16'd6560,  16'd8205,
        16'd9372,  16'd10945, 16'd14071, 16'd14575, 16'd16404, 16'd19661,
        16'd21856, 16'd23429, 16'd24596, 16'd26234, 16'd28089, 16'd28692,
        16'd32781, 16'd37454, 16'd39341, 16'd40986, 16'd42153, 16'd43693,
        16'd45882, 16'd46839, 16'd49172, 16'd51518, 16'd52455, 16'd54611,
        16'd55470, 16'd56177, 16'd57351, 16'd59009, 16'd60097, 16'd60870
    };

    localparam logic [SMOD_W-1:0] MOD_PATTERN [TABLE_ENTRIES] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h11, 8'h21,
        8'h22, 8'h44, 8'h25, 8'h49, 8'h4A, 8'h52, 8'h92, 8'h53, 8'h55,
        8'hAA, 8'h6B, 8'hAD, 8'hB5, 8'hB6, 8'hD6, 8'hB7, 8'hBB, 8'hDD,
        8'hED, 8'hEE, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE
    };

    // Word handed from the front to the divider.
    typedef struct packed {
        logic [WORD_W-1:0] baud_used;
        logic [WORD_W-1:0] clk_hz;
    } ubdc_item_t;

    // One divider stage: partial remainder, quotient so far, operands.
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [WORD_W-1:0] dvs;
        logic [WORD_W-1:0] clk_hz;
    } ubdc_div_t;

    // Pattern of the last threshold at or below the fraction; both sides
    // scaled to a common denominator.
    function automatic logic [SMOD_W-1:0] pick_second_mod(
        input logic [FRACTION_BITS-1:0] frac
    );
        logic [SMOD_W-1:0]              pat;
        logic [FRACTION_BITS+THR_W-1:0] lhs;
        logic [FRACTION_BITS+THR_W-1:0] rhs;
        pat = '0;
        lhs = {frac, {THR_W{1'b0}}};
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            rhs = {MOD_THRESH[k], {FRACTION_BITS{1'b0}}};
            if (lhs >= rhs)
            begin
                pat = MOD_PATTERN[k];
            end
        end
        return pat;
    endfunction

endpackage

FILE: sv/ubdc_front.sv
`timescale 1ns / 1ps
// Front stage: accepts a request, applies the fallback check and registers
// the word for the queue. Depends on ubdc_pkg.
module ubdc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            requested_baud,
    input  logic [31:0]            clk_hz,
    output logic                   item_valid,
    output ubdc_pkg::ubdc_item_t   item,
    input  logic                   item_ready
);
    import ubdc_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    ubdc_item_t item_reg;
    ubdc_item_t item_next;
    logic       fallback;

    // Zero or faster than half the clock falls back.
    assign fallback = (requested_baud == '0) || (requested_baud > (clk_hz >> 1));

    always_comb
    begin
        item_next.baud_used = fallback ? FALLBACK_BAUD : requested_baud;
        item_next.clk_hz    = clk_hz;
    end

    assign in_ready         = !front_valid_reg || item_ready;
    assign front_valid_next = in_ready ? in_valid : front_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = front_valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/ubdc_queue.sv
`timescale 1ns / 1ps
// Short FIFO between the front and the divider so each side stalls alone.
// Depends on ubdc_pkg.
module ubdc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  ubdc_pkg::ubdc_item_t   push_item,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output ubdc_pkg::ubdc_item_t   pop_item
);
    import ubdc_pkg::*;

    ubdc_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/ubdc_back.sv
`timescale 1ns / 1ps
// Back end: pipelined restoring divider, one quotient bit per stage, then
// divisor field decode into the output register. Depends on ubdc_pkg.
module ubdc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  ubdc_pkg::ubdc_item_t   item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            prescaler,
    output logic [3:0]             first_modulator,
    output logic [7:0]             second_modulator,
    output logic                   oversample,
    output logic [31:0]            baud_used,
    output logic                   prescaler_saturated
);
    import ubdc_pkg::*;

    logic                     advance;
    logic [DVD_W-1:0]         stg_vld_reg;
    logic [DVD_W-1:0]         stg_vld_next;
    ubdc_div_t                stg_reg  [DVD_W];
    ubdc_div_t                stg_next [DVD_W];

    ubdc_div_t                last;
    logic [WORD_W-1:0]        whole;
    logic [FRACTION_BITS-1:0] frac;
    logic                     over;
    logic [WORD_W-1:0]        pres_full;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [PRES_W-1:0]        pres_reg;
    logic [PRES_W-1:0]        pres_next;
    logic [FMOD_W-1:0]        fmod_reg;
    logic [FMOD_W-1:0]        fmod_next;
    logic [SMOD_W-1:0]        smod_reg;
    logic [SMOD_W-1:0]        smod_next;
    logic                     over_reg;
    logic [WORD_W-1:0]        baud_reg;
    logic                     sat_reg;
    logic                     sat_next;

    // Whole pipe holds while the output word waits.
    assign advance    = !out_valid_reg || out_ready;
    assign item_ready = advance;

    for (genvar s = 0; s < DVD_W; s++)
    begin : g_stage
        localparam int BIT_IDX = DVD_W - 1 - s;
        ubdc_div_t       prev;
        logic            dbit;
        logic [WORD_W:0] trial;
        logic [WORD_W:0] diff;
        logic            ge;

        if (s == 0)
        begin : g_head
            assign prev = '{rem: '0, quo: '0, dvs: item.baud_used, clk_hz: item.clk_hz};
        end
        else
        begin : g_body
            assign prev = stg_reg[s-1];
        end

        // Dividend is the clock shifted up by the fraction width.
        if (BIT_IDX >= FRACTION_BITS)
        begin : g_clk_bit
            assign dbit = prev.clk_hz[BIT_IDX-FRACTION_BITS];
        end
        else
        begin : g_zero_bit
            assign dbit = 1'b0;
        end

        assign trial = {prev.rem, dbit};
        assign diff  = trial - {1'b0, prev.dvs};
        assign ge    = (trial >= {1'b0, prev.dvs});

        assign stg_next[s] = '{
            rem:    ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0],
            quo:    {prev.quo[QUO_W-2:0], ge},
            dvs:    prev.dvs,
            clk_hz: prev.clk_hz
        };
    end

    assign stg_vld_next = advance ? {stg_vld_reg[DVD_W-2:0], item_valid} : stg_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= '0;
        end
        else
        begin
            stg_vld_reg <= stg_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < DVD_W; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    // Decode the finished quotient.
    assign last      = stg_reg[DVD_W-1];
    assign whole     = last.quo[QUO_W-1:FRACTION_BITS];
    assign frac      = last.quo[FRACTION_BITS-1:0];
    assign over      = (last.quo > OVER_LIMIT_FIX);
    assign pres_full = over ? (whole >> 4) : whole;
    assign sat_next  = (pres_full[WORD_W-1:PRES_W] != '0);
    assign pres_next = sat_next ? {PRES_W{1'b1}} : pres_full[PRES_W-1:0];
    assign fmod_next = over ? whole[FMOD_W-1:0] : '0;
    assign smod_next = pick_second_mod(frac);

    assign out_valid_next = advance ? stg_vld_reg[DVD_W-1] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pres_reg <= pres_next;
            fmod_reg <= fmod_next;
            smod_reg <= smod_next;
            over_reg <= over;
            baud_reg <= last.dvs;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign prescaler           = pres_reg;
    assign first_modulator     = fmod_reg;
    assign second_modulator    = smod_reg;
    assign oversample          = over_reg;
    assign baud_used           = baud_reg;
    assign prescaler_saturated = sat_reg;

endmodule

FILE: sv/uart_baud_divisor_calc.sv
`timescale 1ns / 1ps
// Top level of the UART baud divisor calculator: clock register, front,
// queue and divider back end. Depends on ubdc_pkg and the ubdc_* modules.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    requested_baud
//  out       output     out_valid / out_ready  prescaler, first_modulator,
//                                              second_modulator, oversample,
//                                              baud_used, prescaler_saturated
//  cfg       input      cfg_we                 cfg_wdata (source clock in Hz)
//
// One word per cycle while out_ready stays high; path: front register, one
// queue slot, 48 divider stages of one quotient bit each, output register.
// Reset loads the clock register with 3000000 and empties every stage.
// A held output word freezes the divider; the front and the two-entry queue
// keep taking words until the queue fills.
module uart_baud_divisor_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] requested_baud,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] prescaler,
    output logic [3:0]  first_modulator,
    output logic [7:0]  second_modulator,
    output logic        oversample,
    output logic [31:0] baud_used,
    output logic        prescaler_saturated
);
    import ubdc_pkg::*;

    logic [WORD_W-1:0] clk_hz_reg;
    logic [WORD_W-1:0] clk_hz_next;
    logic              front_valid;
    logic              front_ready;
    ubdc_item_t        front_item;
    logic              queue_valid;
    logic              queue_ready;
    ubdc_item_t        queue_item;

    assign clk_hz_next = cfg_we ? cfg_wdata : clk_hz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLK_HZ_RESET;
        end
        else
        begin
            clk_hz_reg <= clk_hz_next;
        end
    end

    ubdc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .requested_baud (requested_baud),
        .clk_hz         (clk_hz_reg),
        .item_valid     (front_valid),
        .item           (front_item),
        .item_ready     (front_ready)
    );

    ubdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    ubdc_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (queue_valid),
        .item_ready          (queue_ready),
        .item                (queue_item),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .prescaler           (prescaler),
        .first_modulator     (first_modulator),
        .second_modulator    (second_modulator),
        .oversample          (oversample),
        .baud_used           (baud_used),
        .prescaler_saturated (prescaler_saturated)
    );

endmodule

FILE: sv/ubdc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the UART baud divisor calculator, bound to the top
// level. Depends only on the top level's ports.
module ubdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] prescaler,
    input logic [3:0]  first_modulator,
    input logic        oversample,
    input logic [31:0] baud_used,
    input logic        prescaler_saturated
);

    // A stalled output word stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prescaler_saturated |-> prescaler == 16'hFFFF)
        else $error("saturation flag without clipped prescaler");

    a_fmod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !oversample |-> first_modulator == 4'd0)
        else $error("first modulator set without oversampling");

    a_baud_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> baud_used != 32'd0)
        else $error("zero baud rate applied");

endmodule

bind uart_baud_divisor_calc ubdc_checker u_ubdc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .prescaler           (prescaler),
    .first_modulator     (first_modulator),
    .oversample          (oversample),
    .baud_used           (baud_used),
    .prescaler_saturated (prescaler_saturated)
);
